// ===== hw/rtl/macd_pkg.sv =====
// Shared types and constants for the moving average crossover detector.
`default_nettype none

package macd_pkg;

  localparam int SHORT_W  = 8;
  localparam int LONG_W   = 9;
  localparam int SYMBOL_W = 32;
  localparam int PRICE_W  = 32;
  localparam int TIME_W   = 63;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [SHORT_W-1:0]  RST_SHORT  = 8'd10;
  localparam logic [LONG_W-1:0]   RST_LONG   = 9'd30;
  localparam logic [SYMBOL_W-1:0] RST_SYMBOL = 32'd0;

  localparam logic KIND_HISTORY = 1'b0;
  localparam logic KIND_LIVE    = 1'b1;
  localparam logic DIR_BUY      = 1'b0;
  localparam logic DIR_SELL     = 1'b1;

  typedef enum logic [1:0] {
    REG_SHORT  = 2'd0,
    REG_LONG   = 2'd1,
    REG_SYMBOL = 2'd2
  } macd_reg_e;

  typedef struct packed {
    logic                kind;
    logic [PRICE_W-1:0]  close_price;
    logic [TIME_W-1:0]   bar_time;
  } macd_in_t;

  typedef struct packed {
    logic [TIME_W-1:0]   signal_time;
    logic [SYMBOL_W-1:0] signal_symbol;
    logic                direction;
  } macd_out_t;

  typedef struct packed {
    logic [SHORT_W-1:0]  short_period;
    logic [LONG_W-1:0]   long_period;
    logic [SYMBOL_W-1:0] symbol_tag;
  } macd_cfg_t;

  // Bar handed from the window stage to the compare stage.
  typedef struct packed {
    logic              valid;
    logic              live;
    logic [TIME_W-1:0] bar_time;
  } macd_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/macd_cfg.sv =====
// APB register file: window periods and symbol tag.
`default_nettype none

module macd_cfg import macd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      macd_cfg_t          cfg_o,
  output      macd_cfg_t          cfg_nx_o,
  output      logic               restart_o
);

  macd_cfg_t cfg_q, cfg_d;
  macd_reg_e idx;
  logic      wr_en;

  assign pready = 1'b1;
  assign idx    = macd_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d     = cfg_q;
    restart_o = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_SHORT: begin
          cfg_d.short_period = pwdata[SHORT_W-1:0];
          restart_o          = 1'b1;
        end
        REG_LONG: begin
          cfg_d.long_period = pwdata[LONG_W-1:0];
          restart_o         = 1'b1;
        end
        REG_SYMBOL: begin
          cfg_d.symbol_tag = pwdata[SYMBOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SHORT:  prdata = PDATA_W'(cfg_q.short_period);
      REG_LONG:   prdata = PDATA_W'(cfg_q.long_period);
      REG_SYMBOL: prdata = PDATA_W'(cfg_q.symbol_tag);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_period <= RST_SHORT;
      cfg_q.long_period  <= RST_LONG;
      cfg_q.symbol_tag   <= RST_SYMBOL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o    = cfg_q;
  assign cfg_nx_o = cfg_d;

endmodule

`default_nettype wire

// ===== hw/rtl/macd_window.sv =====
// Price ring and running window sums; takes input beats.
`default_nettype none

module macd_window import macd_pkg::*; #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32,
  localparam int AW = $clog2(MAX_WINDOW),
  localparam int LW = $clog2(MAX_WINDOW + 1),
  localparam int RW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W,
  localparam int SW = RW + LW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire macd_cfg_t     cfg_i,
  input  wire macd_cfg_t     cfg_nx_i,
  input  wire logic          restart_i,
  input  wire logic          in_valid_i,
  input  wire macd_in_t      in_data_i,
  output      logic          in_stall_o,
  input  wire logic          p_ready_i,
  output      macd_beat_t    beat_o,
  output      logic [SW-1:0] short_sum_o,
  output      logic [SW-1:0] long_sum_o,
  output      logic [LW-1:0] s_len_o,
  output      logic [LW-1:0] l_len_o
);

  localparam int CW = (LW > LONG_W) ? LW : LONG_W;

  logic [RW-1:0] ring [MAX_WINDOW];

  logic [AW-1:0] wp_q, wp_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [SW-1:0] short_sum_q, short_sum_d;
  logic [SW-1:0] long_sum_q, long_sum_d;
  macd_beat_t    beat_q, beat_d;

  logic [LW-1:0] s_len, l_len, s_len_nx, l_len_nx;
  logic [AW-1:0] rd_addr_s, rd_addr_l;
  logic [RW-1:0] rd_s_q, rd_l_q, wdata_q, old_s, old_l, price;
  logic          byp_s_q, byp_l_q;
  logic          accept, warm, take;

  function automatic logic [LW-1:0] clamp_len(logic [CW-1:0] p);
    logic [LW-1:0] r;
    if (p > CW'(MAX_WINDOW)) r = LW'(MAX_WINDOW);
    else                     r = p[LW-1:0];
    return r;
  endfunction

  // Ring index p entries behind wp.
  function automatic logic [AW-1:0] back_idx(logic [AW-1:0] wp, logic [LW-1:0] p);
    logic [AW:0] t;
    t = (AW+1)'(wp) + (AW+1)'(LW'(MAX_WINDOW) - p);
    if (t >= (AW+1)'(MAX_WINDOW)) t = t - (AW+1)'(MAX_WINDOW);
    return t[AW-1:0];
  endfunction

  assign s_len    = clamp_len(CW'(cfg_i.short_period));
  assign l_len    = clamp_len(CW'(cfg_i.long_period));
  assign s_len_nx = clamp_len(CW'(cfg_nx_i.short_period));
  assign l_len_nx = clamp_len(CW'(cfg_nx_i.long_period));

  assign price      = in_data_i.close_price[RW-1:0];
  assign in_stall_o = beat_q.valid && !p_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign warm       = fill_q >= l_len;
  // live bars before warm-up are dropped with no state change
  assign take       = accept && (in_data_i.kind == KIND_HISTORY || warm);

  // Prefetch the entries leaving the windows for the next beat.
  assign rd_addr_s = back_idx(wp_d, s_len_nx);
  assign rd_addr_l = back_idx(wp_d, l_len_nx);
  assign old_s     = byp_s_q ? wdata_q : rd_s_q;
  assign old_l     = byp_l_q ? wdata_q : rd_l_q;

  always_comb begin
    wp_d        = wp_q;
    fill_d      = fill_q;
    short_sum_d = short_sum_q;
    long_sum_d  = long_sum_q;
    if (restart_i) begin
      wp_d        = '0;
      fill_d      = '0;
      short_sum_d = '0;
      long_sum_d  = '0;
    end else if (take) begin
      wp_d = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
      if (fill_q != LW'(MAX_WINDOW)) fill_d = fill_q + LW'(1);
      if (s_len != '0) begin
        short_sum_d = ((fill_q >= s_len) ? short_sum_q - SW'(old_s) : short_sum_q)
                      + SW'(price);
      end
      if (l_len != '0) begin
        long_sum_d = ((fill_q >= l_len) ? long_sum_q - SW'(old_l) : long_sum_q)
                     + SW'(price);
      end
    end
  end

  always_comb begin
    beat_d = beat_q;
    if (take) begin
      beat_d.valid    = 1'b1;
      beat_d.live     = in_data_i.kind;
      beat_d.bar_time = in_data_i.bar_time;
    end else if (p_ready_i) begin
      beat_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) ring[wp_q] <= price;
    rd_s_q  <= ring[rd_addr_s];
    rd_l_q  <= ring[rd_addr_l];
    wdata_q <= price;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q           <= '0;
      fill_q         <= '0;
      short_sum_q    <= '0;
      long_sum_q     <= '0;
      beat_q.valid   <= 1'b0;
      beat_q.live    <= 1'b0;
      beat_q.bar_time <= '0;
      byp_s_q        <= 1'b0;
      byp_l_q        <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      short_sum_q <= short_sum_d;
      long_sum_q  <= long_sum_d;
      beat_q      <= beat_d;
      byp_s_q     <= take && (wp_q == rd_addr_s);
      byp_l_q     <= take && (wp_q == rd_addr_l);
    end
  end

  assign beat_o      = beat_q;
  assign short_sum_o = short_sum_q;
  assign long_sum_o  = long_sum_q;
  assign s_len_o     = s_len;
  assign l_len_o     = l_len;

`ifndef SYNTHESIS
  a_drop_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.kind == KIND_LIVE && !warm && !restart_i)
    |=> ($stable(fill_q) && $stable(wp_q)))
    else $error("live beat before warm-up changed window state");

  a_take_loads_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (beat_q.valid && beat_q.bar_time == $past(in_data_i.bar_time)))
    else $error("taken beat not handed to compare stage");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/macd_cmp.sv =====
// Cross-multiplied average compare, crossover detect and result register.
`default_nettype none

module macd_cmp import macd_pkg::*; #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32,
  localparam int LW = $clog2(MAX_WINDOW + 1),
  localparam int RW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W,
  localparam int SW = RW + LW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire macd_cfg_t     cfg_i,
  input  wire logic          restart_i,
  input  wire macd_beat_t    beat_i,
  input  wire logic [SW-1:0] short_sum_i,
  input  wire logic [SW-1:0] long_sum_i,
  input  wire logic [LW-1:0] s_len_i,
  input  wire logic [LW-1:0] l_len_i,
  output      logic          p_ready_o,
  output      logic          out_valid_o,
  output      macd_out_t     out_data_o,
  input  wire logic          out_stall_i
);

  localparam int PW = SW + LW;
  localparam int CW = (LW > LONG_W) ? LW : LONG_W;

  logic              p_valid_q, p_live_q, above_q, out_valid_q;
  logic [TIME_W-1:0] p_time_q;
  logic [PW-1:0]     prod_a_q, prod_b_q, prod_a, prod_b;
  macd_out_t         out_q;
  logic              above_new, periods_ok, p_emit, out_free, p_retire;

  assign prod_a = {{LW{1'b0}}, short_sum_i} * {{SW{1'b0}}, l_len_i};
  assign prod_b = {{LW{1'b0}}, long_sum_i} * {{SW{1'b0}}, s_len_i};

  assign periods_ok = (cfg_i.short_period != '0)
                   && ({1'b0, cfg_i.short_period} < cfg_i.long_period)
                   && (CW'(cfg_i.long_period) <= CW'(MAX_WINDOW));

  assign above_new = prod_a_q > prod_b_q;
  assign p_emit    = p_live_q && periods_ok && (above_new != above_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign p_retire  = p_valid_q && (!p_emit || out_free);
  assign p_ready_o = !p_valid_q || p_retire;

  always_ff @(posedge clk_i) begin
    if (p_ready_o) begin
      p_live_q <= beat_i.live;
      p_time_q <= beat_i.bar_time;
      prod_a_q <= prod_a;
      prod_b_q <= prod_b;
    end
    if (p_valid_q && p_emit && out_free) begin
      out_q.signal_time   <= p_time_q;
      out_q.signal_symbol <= cfg_i.symbol_tag;
      out_q.direction     <= above_new ? DIR_BUY : DIR_SELL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      above_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p_ready_o) p_valid_q <= beat_i.valid;
      if (restart_i)     above_q <= 1'b0;
      else if (p_retire) above_q <= above_new;
      if (out_free) out_valid_q <= p_valid_q && p_emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_emit_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && p_emit && out_free)
    |=> (out_valid_q && out_q.signal_time == $past(p_time_q)))
    else $error("crossover beat lost on the way to the result register");

  a_above_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_retire && !restart_i) |=> (above_q == $past(above_new)))
    else $error("comparison state not updated by retired bar");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/moving_average_crossover_detector_top.sv =====
// A bar moves through the window beat, compare and result registers in order.
// Throughput: one bar per cycle when not stalled; set by the single ring write
// and two prefetched ring reads plus two sum updates done in the accept cycle.
// A waiting unread signal stalls input only when a new crossover needs it.
// Reset: periods 10/30, symbol 0, windows empty; ring contents undefined.
`default_nettype none

module moving_average_crossover_detector_top import macd_pkg::*; #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  input  wire logic               in_valid_i,
  input  wire macd_in_t           in_data_i,
  output      logic               in_stall_o,
  output      logic               out_valid_o,
  output      macd_out_t          out_data_o,
  input  wire logic               out_stall_i
);

  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int RW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int SW = RW + LW;

  macd_cfg_t     cfg, cfg_nx;
  logic          restart, p_ready;
  macd_beat_t    beat;
  logic [SW-1:0] short_sum, long_sum;
  logic [LW-1:0] s_len, l_len;

  macd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .cfg_nx_o  (cfg_nx),
    .restart_o (restart)
  );

  macd_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_nx_i    (cfg_nx),
    .restart_i   (restart),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .p_ready_i   (p_ready),
    .beat_o      (beat),
    .short_sum_o (short_sum),
    .long_sum_o  (long_sum),
    .s_len_o     (s_len),
    .l_len_o     (l_len)
  );

  macd_cmp #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .beat_i      (beat),
    .short_sum_i (short_sum),
    .long_sum_i  (long_sum),
    .s_len_i     (s_len),
    .l_len_i     (l_len),
    .p_ready_o   (p_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
